// ===== rtl/cbc_pkg.sv =====
// Shared types, codes and constants for the CSMA-CA backoff controller.
// No dependencies; every other file imports this package.
package cbc_pkg;

   localparam int unsigned ExpWidth     = 3;
   localparam int unsigned WaitWidth    = 7;
   localparam int unsigned RetryWidth   = 8;
   localparam int unsigned AttemptWidth = 9;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 8;

   // Upper bound on any exponent in use.
   localparam logic [ExpWidth:0] ExpLimit = 4'd7;

   // Request kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Register indexes on the CSR port.
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_EXPONENT = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_EXPONENT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_RETRY_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_TRANSMIT = 2'd1,
      ACT_FAILURE  = 2'd2
   } action_type;

   typedef struct packed {
      logic                 kind;
      logic                 channel_clear;
      logic                 frame_start_seen;
      logic [WaitWidth-1:0] random_bits;
   } req_item_type;

   typedef struct packed {
      action_type              action;
      logic                    busy_res;
      logic [AttemptWidth-1:0] attempts_remaining;
   } rsp_item_type;

   typedef struct packed {
      logic [ExpWidth-1:0]   min_exponent;
      logic [ExpWidth-1:0]   max_exponent;
      logic [RetryWidth-1:0] retry_count;
   } cfg_type;

   function automatic logic [ExpWidth-1:0] cap_exp(input logic [ExpWidth-1:0] e);
      logic [ExpWidth:0] wide;
      wide = {1'b0, e};
      return (wide > ExpLimit) ? ExpLimit[ExpWidth-1:0] : e;
   endfunction

endpackage

// ===== rtl/cbc_if.sv =====
// Request and response channel interfaces for the backoff controller.
// Depends on cbc_pkg for field widths.
interface cbc_req_if;
   import cbc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic                 channel_clear;
   logic                 frame_start_seen;
   logic [WaitWidth-1:0] random_bits;

   modport source (output valid, kind, channel_clear, frame_start_seen, random_bits,
                   input ready);
   modport sink   (input valid, kind, channel_clear, frame_start_seen, random_bits,
                   output ready);
endinterface

interface cbc_rsp_if;
   import cbc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic                    busy_res;
   logic [AttemptWidth-1:0] attempts_remaining;

   modport source (output valid, action, busy_res, attempts_remaining, input ready);
   modport sink   (input valid, action, busy_res, attempts_remaining, output ready);
endinterface

// ===== rtl/cbc_draw.sv =====
// Backoff draw: masks the random value by the exponent and raises the exponent.
// Depends on cbc_pkg.
module cbc_draw (
   input  logic [cbc_pkg::ExpWidth-1:0]  exponent,
   input  logic [cbc_pkg::ExpWidth-1:0]  max_exponent,
   input  logic [cbc_pkg::WaitWidth-1:0] random_bits,
   output logic [cbc_pkg::WaitWidth-1:0] wait_len,
   output logic [cbc_pkg::ExpWidth-1:0]  exponent_next
);
   import cbc_pkg::*;

   logic [ExpWidth-1:0]  exp_capped;
   logic [ExpWidth-1:0]  ceiling;
   logic [ExpWidth:0]    raised;
   logic [WaitWidth:0]   mask;

   always_comb begin
      exp_capped = cap_exp(exponent);
      ceiling    = cap_exp(max_exponent);
      // (1 << e) - 1; zero exponent gives an empty mask
      mask       = ((WaitWidth+1)'(1) << exp_capped) - (WaitWidth+1)'(1);
      wait_len   = random_bits & mask[WaitWidth-1:0];
      raised     = {1'b0, exp_capped} + (ExpWidth+1)'(1);
      exponent_next = (raised > {1'b0, ceiling}) ? ceiling : raised[ExpWidth-1:0];
   end

endmodule

// ===== rtl/cbc_core.sv =====
// Access state registers and the per-request update logic.
// Depends on cbc_pkg and cbc_draw.
module cbc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  cbc_pkg::req_item_type item,
   input  cbc_pkg::cfg_type      cfg,
   output cbc_pkg::rsp_item_type result
);
   import cbc_pkg::*;

   logic                    active_ff,    active_in;
   logic [WaitWidth-1:0]    wait_left_ff, wait_left_in;
   logic [ExpWidth-1:0]     exponent_ff,  exponent_in;
   logic [AttemptWidth-1:0] attempts_ff,  attempts_in;

   logic [ExpWidth-1:0]     draw_exp;
   logic [WaitWidth-1:0]    draw_wait;
   logic [ExpWidth-1:0]     draw_exp_next;
   logic [AttemptWidth-1:0] attempts_dec;
   action_type              action;

   // A start draws from the configured minimum, a retry from the held exponent.
   assign draw_exp = (item.kind == KIND_START) ? cap_exp(cfg.min_exponent) : exponent_ff;

   cbc_draw u_draw (
      .exponent      (draw_exp),
      .max_exponent  (cfg.max_exponent),
      .random_bits   (item.random_bits),
      .wait_len      (draw_wait),
      .exponent_next (draw_exp_next)
   );

   // Saturate at zero on the busy path.
   assign attempts_dec = (attempts_ff != '0) ? attempts_ff - AttemptWidth'(1) : attempts_ff;

   always_comb begin
      active_in    = active_ff;
      wait_left_in = wait_left_ff;
      exponent_in  = exponent_ff;
      attempts_in  = attempts_ff;
      action       = ACT_NONE;
      priority if (item.kind == KIND_START) begin
         active_in    = 1'b1;
         attempts_in  = {1'b0, cfg.retry_count} + AttemptWidth'(1);
         wait_left_in = draw_wait;
         exponent_in  = draw_exp_next;
      end else if (!active_ff) begin
         // idle tick: hold everything
      end else if (wait_left_ff != '0) begin
         wait_left_in = wait_left_ff - WaitWidth'(1);
      end else if (item.channel_clear && !item.frame_start_seen) begin
         action    = ACT_TRANSMIT;
         active_in = 1'b0;
      end else begin
         attempts_in = attempts_dec;
         if (attempts_dec == '0) begin
            action    = ACT_FAILURE;
            active_in = 1'b0;
         end else begin
            wait_left_in = draw_wait;
            exponent_in  = draw_exp_next;
         end
      end
      result.action             = action;
      result.busy_res           = active_in;
      result.attempts_remaining = attempts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         wait_left_ff <= '0;
         exponent_ff  <= '0;
         attempts_ff  <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         wait_left_ff <= wait_left_in;
         exponent_ff  <= exponent_in;
         attempts_ff  <= attempts_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_start_activates: assert property (@(posedge clock) disable iff (reset)
      step && item.kind == KIND_START |=> active_ff)
      else $error("start did not activate access");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step && action != ACT_NONE |=> !active_ff)
      else $error("transmit or failure left access active");

   a_wait_counts_down: assert property (@(posedge clock) disable iff (reset)
      step && item.kind == KIND_TICK && active_ff && wait_left_ff != '0
      |=> wait_left_ff == $past(wait_left_ff) - WaitWidth'(1))
      else $error("backoff wait did not count down by one");

   a_failure_zero: assert property (@(posedge clock) disable iff (reset)
      step && action == ACT_FAILURE |=> attempts_ff == '0)
      else $error("failure reported with attempts left");
`endif

endmodule

// ===== rtl/csma_ca_backoff_controller.sv =====
// Top level of the unslotted CSMA-CA backoff controller: CSR bank, request
// register and response register around cbc_core. Depends on cbc_pkg, cbc_if and cbc_core.
// Usage:
//   req_chan carries one request per handshake: a start (kind 0) opens a
//   channel access, a tick (kind 1) marks one elapsed backoff period and
//   carries the CCA result and frame start flag sampled for it; random_bits
//   feeds any wait drawn by that request.
//   rsp_chan returns exactly one response per request, in order: the action
//   (none, transmit now, access failure), busy flag and attempts left.
//   csr_* writes min_exponent, max_exponent and retry_count; write only while
//   no request is in flight.
// Timing:
//   A request lands in the request register, is evaluated combinationally
//   against the access state and loads the response register when it
//   advances. One request per cycle is sustained while rsp_chan.ready
//   stays high; the only loop is the access state update in cbc_core.
// Reset (synchronous, active high): access idle, wait, exponent and attempts
//   zero, registers back to min 3 / max 5 / retries 4, both stages empty.
// Stalls: while a response is offered and rsp_chan.ready is low, it holds,
//   the request stage holds its request, req_chan.ready drops once it is full.
module csma_ca_backoff_controller (
   input  logic                               clock,
   input  logic                               reset,
   cbc_req_if.sink                            req_chan,
   cbc_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [cbc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [cbc_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import cbc_pkg::*;

   cfg_type      cfg_ff;
   req_item_type req_item_ff;
   logic         req_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type core_result;
   logic         step;
   logic         req_take;

   // Advance when a request is held and the response slot is free or draining.
   assign step     = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || step;
   assign req_take = req_chan.valid && req_chan.ready;

   // CSR bank; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_exponent <= 3'd3;
         cfg_ff.max_exponent <= 3'd5;
         cfg_ff.retry_count  <= 8'd4;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_EXPONENT: cfg_ff.min_exponent <= csr_wdata[ExpWidth-1:0];
            CSR_MAX_EXPONENT: cfg_ff.max_exponent <= csr_wdata[ExpWidth-1:0];
            CSR_RETRY_COUNT:  cfg_ff.retry_count  <= csr_wdata[RetryWidth-1:0];
            default: ;
         endcase
      end
   end

   // Request stage: hold the request until the core takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.kind             <= req_chan.kind;
         req_item_ff.channel_clear    <= req_chan.channel_clear;
         req_item_ff.frame_start_seen <= req_chan.frame_start_seen;
         req_item_ff.random_bits      <= req_chan.random_bits;
      end
   end

   cbc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // Response stage: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.action             = rsp_item_ff.action;
   assign rsp_chan.busy_res           = rsp_item_ff.busy_res;
   assign rsp_chan.attempts_remaining = rsp_item_ff.attempts_remaining;

`ifndef NO_ASSERTIONS
   a_step_needs_slot: assert property (@(posedge clock) disable iff (reset)
      step |-> req_valid_ff && (!rsp_valid_ff || rsp_chan.ready))
      else $error("advance without a request or a free response slot");

   a_held_request_advances: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_valid_ff |-> step)
      else $error("request stage stalled with an empty response slot");

   a_response_after_step: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("advanced request produced no response");
`endif

endmodule
